/* hw/rtl/scht_pkg.sv */
// scht_pkg: shared constants, types and helpers for the swept circle hit test
// used by scht_div, scht_dp, scht_ctrl and the top level; depends on nothing else
package scht_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int ANGLE_BITS  = 12;
    localparam int SAMPLE_W    = $clog2(MAX_SAMPLES + 1);
    localparam int QUO_W       = 15;
    localparam int NUM_W       = 48;
    localparam int DEN_W       = 33;
    localparam int POS_W       = 24;
    localparam int STEP_W      = 4;
    localparam int PROD_W      = 29;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_PREP_S, S_START_S, S_WAIT_S, S_PREP_C, S_START_C,
        S_WAIT_C, S_START_N, S_WAIT_N, S_MUL, S_POS, S_SAMPLE, S_FINAL,
        S_DRAIN, S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic calc_p;
        logic ang_cos;
        logic div_start;
        logic div_cnt;
        logic store_sin;
        logic store_cos;
        logic store_cnt;
        logic mul;
        logic set_pos;
        logic sample_issue;
        logic final_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic div_done;
        logic n_one;
        logic pipe_empty;
        logic out_free;
    } t_stat;

    // round half up of v / 2^14
    function automatic logic signed [15:0] rnd14(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] w;
        w = v + PROD_W'(8192);
        return 16'(w >>> 14);
    endfunction

endpackage

/* hw/rtl/scht_div.sv */
// scht_div: restoring divider, one quotient bit per cycle
// depends on scht_pkg
module scht_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [scht_pkg::NUM_W-1:0]  i_num,
    input  logic [scht_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [scht_pkg::QUO_W-1:0]  o_quo
);
    import scht_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsh;
    logic [QUO_W-1:0]  r_q;
    logic              ge;

    assign ge = r_rem >= r_dsh;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= NUM_W'({i_den, {(QUO_W - 1){1'b0}}});
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[QUO_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

/* hw/rtl/scht_dp.sv */
// scht_dp: datapath, operand registers, trig and count division, sample pipeline
// depends on scht_pkg and scht_div
module scht_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scht_pkg::t_cmd       i_cmd,
    output scht_pkg::t_stat      o_stat,
    input  logic                 i_bullet_active,
    input  logic signed [15:0]   i_bullet_x,
    input  logic signed [15:0]   i_bullet_y,
    input  logic [11:0]          i_bullet_speed,
    input  logic [11:0]          i_bullet_radius,
    input  logic [11:0]          i_bullet_heading,
    input  logic signed [15:0]   i_target_x,
    input  logic signed [15:0]   i_target_y,
    input  logic [11:0]          i_target_radius,
    input  logic [7:0]           i_bullet_slot,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_hit,
    output logic [7:0]           o_hit_slot
);
    import scht_pkg::*;

    // latched item
    logic                     r_act;
    logic signed [15:0]       r_bx, r_by, r_tx, r_ty;
    logic [11:0]              r_spd, r_head;
    logic [12:0]              r_r;
    logic [25:0]              r_r2;
    logic [7:0]               r_slot;

    // trig and count
    logic [28:0]              r_p;
    logic                     r_neg;
    logic signed [15:0]       r_s, r_c;
    logic [SAMPLE_W-1:0]      r_n;
    logic signed [PROD_W-1:0] r_mbx, r_mby, r_msx, r_msy;
    logic signed [POS_W-1:0]  r_px, r_py;
    logic signed [15:0]       r_sx, r_sy;

    // sample pipeline
    logic                     r_v1, r_v2, r_hit, r_ov;
    logic signed [POS_W-1:0]  r_dx, r_dy;
    logic signed [47:0]       r_qx, r_qy;

    logic [15:0]              t_base, t_ang;
    logic [14:0]              u;
    logic [DEN_W-1:0]         d_trig, div_den;
    logic [NUM_W-1:0]         div_num;
    logic [QUO_W-1:0]         quo;
    logic                     div_done;
    logic signed [15:0]       q_sgn;
    logic signed [12:0]       spd13, r13;
    logic signed [POS_W-1:0]  sel_x, sel_y;
    logic [NUM_W-1:0]         dist2;

    // angle as a 16-bit turn
    assign t_base = 16'({r_head[ANGLE_BITS-1:0], {(16 - ANGLE_BITS){1'b0}}});
    assign t_ang  = i_cmd.ang_cos ? t_base + 16'd16384 : t_base;
    assign u      = t_ang[14:0];

    // divider operands
    assign d_trig  = 33'h1_4000_0000 - DEN_W'({r_p, 2'b00});
    assign div_num = i_cmd.div_cnt ? NUM_W'(r_spd) + NUM_W'(r_r) - NUM_W'(1)
                                   : NUM_W'({r_p, 18'b0}) + NUM_W'(d_trig >> 1);
    assign div_den = i_cmd.div_cnt ? DEN_W'(r_r) : d_trig;

    scht_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign q_sgn = r_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign spd13 = $signed({1'b0, r_spd});
    assign r13   = $signed(r_r);
    assign sel_x = i_cmd.sample_issue ? r_px : POS_W'(r_bx);
    assign sel_y = i_cmd.sample_issue ? r_py : POS_W'(r_by);
    assign dist2 = NUM_W'(r_qx) + NUM_W'(r_qy);

    // operand and trig registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_bullet_active;
            r_bx   <= i_bullet_x;
            r_by   <= i_bullet_y;
            r_tx   <= i_target_x;
            r_ty   <= i_target_y;
            r_spd  <= i_bullet_speed;
            r_head <= i_bullet_heading;
            r_r    <= 13'(i_bullet_radius) + 13'(i_target_radius);
            r_slot <= i_bullet_slot;
        end
        r_r2 <= r_r * r_r;
        if (i_cmd.calc_p) begin
            r_p   <= 29'(u) * 29'(16'd32768 - {1'b0, u});
            r_neg <= t_ang[15];
        end
        if (i_cmd.store_sin) r_s <= q_sgn;
        if (i_cmd.store_cos) r_c <= q_sgn;
        if (i_cmd.mul) begin
            r_mbx <= r_c * spd13;
            r_mby <= r_s * spd13;
            r_msx <= r_c * r13;
            r_msy <= r_s * r13;
        end
        if (i_cmd.store_cnt) begin
            r_n <= (quo > QUO_W'(MAX_SAMPLES)) ? SAMPLE_W'(MAX_SAMPLES)
                                               : SAMPLE_W'(quo);
        end else if (i_cmd.sample_issue) begin
            r_n <= r_n - 1'b1;
        end
        if (i_cmd.set_pos) begin
            r_px <= POS_W'(r_bx) - POS_W'(rnd14(r_mbx));
            r_py <= POS_W'(r_by) - POS_W'(rnd14(r_mby));
            r_sx <= rnd14(r_msx);
            r_sy <= rnd14(r_msy);
        end else if (i_cmd.sample_issue) begin
            r_px <= r_px + POS_W'(r_sx);
            r_py <= r_py + POS_W'(r_sy);
        end
        // distance and square stages
        r_dx <= sel_x - POS_W'(r_tx);
        r_dy <= sel_y - POS_W'(r_ty);
        r_qx <= r_dx * r_dx;
        r_qy <= r_dy * r_dy;
        if (i_cmd.out_load) begin
            o_hit      <= r_hit;
            o_hit_slot <= r_slot;
        end
    end

    // pipeline valids, hit flag, output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_hit <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_v1 <= i_cmd.sample_issue | i_cmd.final_issue;
            r_v2 <= r_v1;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_v2 && r_act && (dist2 < NUM_W'(r_r2))) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_ov;
    assign o_stat.skip       = !r_act || (r_r == '0) || ({1'b0, r_spd} <= r_r);
    assign o_stat.div_done   = div_done;
    assign o_stat.n_one      = (r_n == SAMPLE_W'(1));
    assign o_stat.pipe_empty = !r_v1 && !r_v2;
    assign o_stat.out_free   = !r_ov || i_out_ready;
endmodule

/* hw/rtl/scht_ctrl.sv */
// scht_ctrl: sequencer for one item at a time
// depends on scht_pkg
module scht_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  scht_pkg::t_stat  i_stat,
    output scht_pkg::t_cmd   o_cmd
);
    import scht_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE:  n_state = i_stat.skip ? S_FINAL : S_PREP_S;
            S_PREP_S:  n_state = S_START_S;
            S_START_S: n_state = S_WAIT_S;
            S_WAIT_S:  if (i_stat.div_done) n_state = S_PREP_C;
            S_PREP_C:  n_state = S_START_C;
            S_START_C: n_state = S_WAIT_C;
            S_WAIT_C:  if (i_stat.div_done) n_state = S_START_N;
            S_START_N: n_state = S_WAIT_N;
            S_WAIT_N:  if (i_stat.div_done) n_state = S_MUL;
            S_MUL:     n_state = S_POS;
            S_POS:     n_state = S_SAMPLE;
            S_SAMPLE:  if (i_stat.n_one) n_state = S_FINAL;
            S_FINAL:   n_state = S_DRAIN;
            S_DRAIN:   if (i_stat.pipe_empty) n_state = S_DONE;
            S_DONE:    if (i_stat.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PREP_S:  o_cmd.calc_p = 1'b1;
            S_START_S: o_cmd.div_start = 1'b1;
            S_PREP_C: begin
                o_cmd.store_sin = 1'b1;
                o_cmd.calc_p    = 1'b1;
                o_cmd.ang_cos   = 1'b1;
            end
            S_START_C: o_cmd.div_start = 1'b1;
            S_START_N: begin
                o_cmd.store_cos = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_cnt   = 1'b1;
            end
            S_WAIT_N:  o_cmd.div_cnt = 1'b1;
            S_MUL: begin
                o_cmd.store_cnt = 1'b1;
                o_cmd.mul       = 1'b1;
                o_cmd.div_cnt   = 1'b1;
            end
            S_POS:     o_cmd.set_pos = 1'b1;
            S_SAMPLE:  o_cmd.sample_issue = 1'b1;
            S_FINAL:   o_cmd.final_issue = 1'b1;
            S_DONE:    o_cmd.out_load = i_stat.out_free;
            default:   o_cmd = '0;
        endcase
    end
endmodule

/* hw/rtl/swept_circle_hit_test_top.sv */
// swept_circle_hit_test_top: one result beat per input beat, one item at a time
// when only the current position is tested, the sequencer goes straight to the final
// check; otherwise three passes of the shared divider (sine, cosine, sample count) come
// first, then n = min(ceil(speed / hit radius), 64) path samples at one sample per cycle
// the next input beat can be taken in the cycle after the result is loaded; each item
// can also wait on a still-full result register
// reset: synchronous active low, clears the sequencer and the output beat
module swept_circle_hit_test_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_bullet_active,
    input  logic signed [15:0]  i_bullet_x,
    input  logic signed [15:0]  i_bullet_y,
    input  logic [11:0]         i_bullet_speed,
    input  logic [11:0]         i_bullet_radius,
    input  logic [11:0]         i_bullet_heading,
    input  logic signed [15:0]  i_target_x,
    input  logic signed [15:0]  i_target_y,
    input  logic [11:0]         i_target_radius,
    input  logic [7:0]          i_bullet_slot,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_hit,
    output logic [7:0]          o_hit_slot
);
    import scht_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    scht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    scht_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_bullet_active  (i_bullet_active),
        .i_bullet_x       (i_bullet_x),
        .i_bullet_y       (i_bullet_y),
        .i_bullet_speed   (i_bullet_speed),
        .i_bullet_radius  (i_bullet_radius),
        .i_bullet_heading (i_bullet_heading),
        .i_target_x       (i_target_x),
        .i_target_y       (i_target_y),
        .i_target_radius  (i_target_radius),
        .i_bullet_slot    (i_bullet_slot),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_hit            (o_hit),
        .o_hit_slot       (o_hit_slot)
    );
endmodule

/* hw/rtl/scht_checker.sv */
// scht_checker: port-level checks on the hit test top level, with its bind
// depends on swept_circle_hit_test_top ports only
module scht_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_hit,
    input logic [7:0] o_hit_slot
);
    // result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit)
            && $stable(o_hit_slot))
        else $error("result beat changed while stalled");

    // one item in flight: input closes after a beat is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat after reset");

    // a new result appears as the block reopens for input
    a_result_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while still busy");
endmodule

bind swept_circle_hit_test_top scht_checker u_scht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_hit       (o_hit),
    .o_hit_slot  (o_hit_slot)
);

/* tb/tb.sv */
// tb: self-checking bench for swept_circle_hit_test_top, fixed-point hit predictor
// and a small result scoreboard; depends on scht_pkg and the top module
`timescale 1ns / 100ps

class hit_scoreboard;
    bit [8:0] pending_q[$];
    int       err_cnt;

    // bullet is within r when dx^2 + dy^2 < r^2
    static function bit within_r(longint dx, longint dy, longint r2);
        return (dx * dx + dy * dy) < r2;
    endfunction

    // q1.14 sine of a 16-bit turn
    static function longint sine_q14(int unsigned t);
        longint u, p, d, s;
        u = t & 32'h7fff;
        p = u * (32768 - u);
        d = (longint'(5) << 30) - 4 * p;
        s = ((p << 18) + d / 2) / d;
        return (t & 32'h8000) ? -s : s;
    endfunction

    // round half up of v / 2^14
    static function longint round_q14(longint v);
        longint b;
        b = v + (longint'(1) << 40) + 8192;
        return (b >>> 14) - (longint'(1) << 26);
    endfunction

    function void report_err(string msg);
        $display("mismatch: %s", msg);
        err_cnt++;
    endfunction

    function void note_beat(bit act, shortint bx, shortint by, bit [11:0] spd,
                            bit [11:0] brad, bit [11:0] hdg, shortint tx,
                            shortint ty, bit [11:0] trad, bit [7:0] slot);
        longint r, r2, s, c, px, py, sx, sy, n, k, speed;
        int unsigned t;
        bit hit;
        hit = 0;
        speed = spd;
        if (act) begin
            r  = longint'(brad) + longint'(trad);
            r2 = r * r;
            if (speed > r && r > 0) begin
                t  = (int'(hdg) << (16 - scht_pkg::ANGLE_BITS)) & 32'hffff;
                s  = sine_q14(t);
                c  = sine_q14((t + 16384) & 32'hffff);
                px = bx - round_q14(c * speed);
                py = by - round_q14(s * speed);
                sx = round_q14(c * r);
                sy = round_q14(s * r);
                n  = (speed + r - 1) / r;
                if (n > scht_pkg::MAX_SAMPLES) n = scht_pkg::MAX_SAMPLES;
                for (k = 0; k < n && !hit; k++) begin
                    if (within_r(px - tx, py - ty, r2)) hit = 1;
                    px += sx;
                    py += sy;
                end
            end
            if (!hit && within_r(bx - tx, by - ty, r2)) hit = 1;
        end
        pending_q.insert(pending_q.size(), {hit, slot});
    endfunction

    function void check_beat(bit hit, bit [7:0] slot);
        bit [8:0] exp_beat;
        if (pending_q.size() == 0) begin
            report_err($sformatf("result beat with nothing pending slot=%0d", slot));
            return;
        end
        exp_beat = pending_q.pop_front();
        if (exp_beat[8] !== hit)
            report_err($sformatf("hit %0b expected %0b slot %0d", hit, exp_beat[8], slot));
        if (exp_beat[7:0] !== slot)
            report_err($sformatf("hit_slot %0d expected %0d", slot, exp_beat[7:0]));
    endfunction
endclass

module tb;
    import scht_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_in_valid = 0;
    logic               o_in_ready;
    logic               i_bullet_active = 0;
    logic signed [15:0] i_bullet_x = 0, i_bullet_y = 0;
    logic [11:0]        i_bullet_speed = 0, i_bullet_radius = 0, i_bullet_heading = 0;
    logic signed [15:0] i_target_x = 0, i_target_y = 0;
    logic [11:0]        i_target_radius = 0;
    logic [7:0]         i_bullet_slot = 0;
    logic               o_out_valid;
    logic               i_out_ready = 0;
    logic               o_hit;
    logic [7:0]         o_hit_slot;

    hit_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    bit stim_done = 0;

    swept_circle_hit_test_top dut (.*);

    always #6 i_clk = ~i_clk;

    // one input beat, with a random idle gap first, and wait for acceptance
    task automatic send_beat(bit act, shortint bx, shortint by, bit [11:0] spd,
                             bit [11:0] brad, bit [11:0] hdg, shortint tx,
                             shortint ty, bit [11:0] trad, bit [7:0] slot);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        i_in_valid       <= 1;
        i_bullet_active  <= act;
        i_bullet_x       <= bx;
        i_bullet_y       <= by;
        i_bullet_speed   <= spd;
        i_bullet_radius  <= brad;
        i_bullet_heading <= hdg;
        i_target_x       <= tx;
        i_target_y       <= ty;
        i_target_radius  <= trad;
        i_bullet_slot    <= slot;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(act, bx, by, spd, brad, hdg, tx, ty, trad, slot);
        @(negedge i_clk);
    endtask

    // random beat, mostly near misses with small radii so paths are sampled
    task automatic send_random(int idx);
        shortint bx, by, tx, ty;
        bit [11:0] spd, brad, trad;
        bx = shortint'($urandom);
        by = shortint'($urandom);
        case ($urandom_range(3))
            0: begin tx = shortint'($urandom); ty = shortint'($urandom); end
            default: begin
                tx = bx + shortint'($urandom_range(0, 8191)) - 4096;
                ty = by + shortint'($urandom_range(0, 8191)) - 4096;
            end
        endcase
        brad = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 200));
        trad = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 200));
        spd  = 12'($urandom);
        send_beat($urandom_range(9) != 0, bx, by, spd, brad, 12'($urandom),
                  tx, ty, trad, 8'(idx));
    endtask

    // receiver stalls, with long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_beat(o_hit, o_hit_slot);
    end

    initial begin
        int i;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: extremes, inactive, zero radius, no sweep, saturation
        send_beat(0, 0, 0, 0, 10, 0, 0, 0, 10, 8'd1);
        send_beat(1, 0, 0, 0, 10, 0, 0, 0, 10, 8'd2);
        send_beat(1, 0, 0, 100, 0, 0, 0, 0, 0, 8'd3);
        send_beat(1, 0, 0, 4095, 1, 0, -16'sd2000, 0, 0, 8'd4);
        send_beat(1, 0, 0, 4095, 1, 12'd2048, 16'sd2000, 0, 0, 8'd5);
        send_beat(1, 32767, 32767, 4095, 4095, 12'hfff, -32768, -32768, 4095, 8'hff);
        send_beat(1, -32768, -32768, 4095, 0, 12'd1024, -32768, -32768, 1, 8'd0);
        send_beat(1, 100, 0, 500, 20, 0, 0, 0, 20, 8'd7);
        send_beat(1, 0, 100, 500, 20, 12'd1024, 0, -300, 20, 8'd8);
        send_beat(1, 0, 0, 40, 20, 12'd3072, 0, 0, 20, 8'd9);
        send_beat(1, 0, 0, 41, 10, 12'd512, 100, 100, 10, 8'd10);
        send_beat(1, 0, 0, 30, 15, 0, 29, 0, 15, 8'd11);
        send_beat(1, 0, 0, 30, 15, 0, 30, 0, 15, 8'd12);
        send_beat(1, 0, 0, 4095, 4095, 0, 0, 0, 4095, 8'd13);
        send_beat(1, 32767, -32768, 2000, 30, 12'd2560, 32767, -32768, 0, 8'd14);

        // random phases: none, sender idle, receiver stall, both
        for (i = 0; i < 1150; i++) begin
            case (i / 280)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (i == 100) hold_cycles <= 600;
            send_random(i);
        end
        i_in_valid <= 0;
        stim_done = 1;
    end

    // drain and finish
    initial begin
        wait (stim_done);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.err_cnt == 0 && sb.pending_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/scht_pkg.sv
hw/rtl/scht_div.sv
hw/rtl/scht_dp.sv
hw/rtl/scht_ctrl.sv
hw/rtl/swept_circle_hit_test_top.sv
hw/rtl/scht_checker.sv
tb/tb.sv
